// ----- src/fdlr_pkg.sv -----
package fdlr_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MaxDepthDef    = 131072;
  localparam int unsigned SampleWidthDef = 16;

  // One lane per stereo channel.
  localparam int unsigned NumLanes = 2;

  // Register field widths.
  localparam int unsigned CfgLenW  = 18;
  localparam int unsigned CfgDlyW  = 17;
  localparam int unsigned GainW    = 16;
  localparam int unsigned GainFrac = 15;

  // APB port widths.
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] RegBufLen  = 2'd0;
  localparam logic [1:0] RegDelay   = 2'd1;
  localparam logic [1:0] RegGain    = 2'd2;
  localparam logic [1:0] RegReverse = 2'd3;

  // Register reset values.
  localparam logic [CfgLenW-1:0] BufLenRst = 18'd96000;
  localparam logic [CfgDlyW-1:0] DelayRst  = 17'd24000;
  localparam logic [GainW-1:0]   GainRst   = 16'd16384;

  // Strobes from the sequencer to every lane.
  typedef struct packed {
    logic rd_en;
    logic mul_en;
    logic wr_en;
    logic clr_en;
    logic hit;
  } lane_ctrl_t;

endpackage

// ----- src/feedback_delay_line_reverse.sv -----
// Sequence: an accepted request passes five steps in order (two address steps, the
// mirror and store read, one multiply, then add, saturate and write-back); the last
// step waits while the output register still holds an untaken result. The next
// request is taken only once the sequencer is idle again. A request with a rising
// transport flag first clears all MAX_DEPTH entries of the store. Reset clears the
// registers and then runs the same clearing pass, taking no request.
module feedback_delay_line_reverse import fdlr_pkg::*; #(
  parameter int unsigned MAX_DEPTH    = MaxDepthDef,
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ApbAddrW-1:0]            paddr,
  input  logic [ApbDataW-1:0]            pwdata,
  output logic [ApbDataW-1:0]            prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] left_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0] right_in_i,
  input  logic                           transport_playing_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] left_out_o,
  output logic signed [SAMPLE_WIDTH-1:0] right_out_o
);

  localparam int unsigned AW = $clog2(MAX_DEPTH);
  localparam int unsigned LW = (CfgLenW > AW + 1) ? CfgLenW : AW + 1;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StClear = 3'd1;
  localparam logic [2:0] StCalc1 = 3'd2;
  localparam logic [2:0] StCalc2 = 3'd3;
  localparam logic [2:0] StRead  = 3'd4;
  localparam logic [2:0] StMul   = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  logic [CfgLenW-1:0] buf_len_q;
  logic [CfgDlyW-1:0] delay_q;
  logic [GainW-1:0]   gain_q;
  logic               reverse_q;
  logic               cfg_wr;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] wp_q, wp_d;
  logic          was_playing_q, was_playing_d;
  logic          pend_q, pend_d;
  logic          out_valid_q, out_valid_d;

  logic [AW:0]   len_d, len_q;
  logic [AW-1:0] dly_d, dly_q;
  logic [AW-1:0] wpe_d, wpe_q;
  logic [AW-1:0] tap_d, tap_q;
  logic          hit_d, hit_q;

  logic [LW-1:0] len_ext, len_c, dly_ext, dly_c;
  logic [AW:0]   tap_wrap, mirror, wp_inc;
  logic [AW-1:0] rd_addr, wr_addr;

  logic                          accept, out_free, clr_last;
  logic signed [SAMPLE_WIDTH-1:0] sample_q [NumLanes];
  logic signed [SAMPLE_WIDTH-1:0] result   [NumLanes];
  logic signed [SAMPLE_WIDTH-1:0] out_q    [NumLanes];
  lane_ctrl_t                     lane_ctrl;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_len_q <= BufLenRst;
      delay_q   <= DelayRst;
      gain_q    <= GainRst;
      reverse_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegBufLen:  buf_len_q <= pwdata[CfgLenW-1:0];
        RegDelay:   delay_q   <= pwdata[CfgDlyW-1:0];
        RegGain:    gain_q    <= pwdata[GainW-1:0];
        RegReverse: reverse_q <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegBufLen:  prdata = ApbDataW'(buf_len_q);
      RegDelay:   prdata = ApbDataW'(delay_q);
      RegGain:    prdata = ApbDataW'(gain_q);
      RegReverse: prdata = ApbDataW'(reverse_q);
      default:    prdata = '0;
    endcase
  end

  // First step: effective length, delay and write pointer.
  always_comb begin
    len_ext = LW'(buf_len_q);
    if (len_ext < LW'(2)) begin
      len_c = LW'(2);
    end else if (len_ext > LW'(MAX_DEPTH)) begin
      len_c = LW'(MAX_DEPTH);
    end else begin
      len_c = len_ext;
    end
    len_d   = len_c[AW:0];
    dly_ext = LW'(delay_q);
    dly_c   = (dly_ext >= len_c) ? len_c - LW'(1) : dly_ext;
    dly_d   = dly_c[AW-1:0];
    wpe_d   = ({1'b0, wp_q} >= len_d) ? '0 : wp_q;
  end

  // Second step: tap position behind the write pointer, wrapped into the store.
  assign tap_wrap = {1'b0, wpe_q} + len_q - {1'b0, dly_q};
  assign tap_d    = (wpe_q >= dly_q) ? wpe_q - dly_q : tap_wrap[AW-1:0];

  // Third step: optional mirror of the tap, then the store read.
  assign mirror  = len_q - (AW+1)'(1) - {1'b0, tap_q};
  assign rd_addr = reverse_q ? mirror[AW-1:0] : tap_q;
  assign hit_d   = (rd_addr == wpe_q);
  assign wr_addr = (state_q == StClear) ? clr_q : wpe_q;

  assign wp_inc   = {1'b0, wpe_q} + (AW+1)'(1);
  assign accept   = in_valid_i & in_ready_o;
  assign out_free = ~out_valid_q | out_ready_i;
  assign clr_last = (clr_q == AW'(MAX_DEPTH - 1));

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    wp_d          = wp_q;
    was_playing_d = was_playing_q;
    pend_d        = pend_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    lane_ctrl     = '0;
    lane_ctrl.hit = hit_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          was_playing_d = transport_playing_i;
          pend_d        = 1'b1;
          clr_d         = '0;
          state_d       = (transport_playing_i & ~was_playing_q) ? StClear : StCalc1;
        end
      end
      StClear: begin
        lane_ctrl.clr_en = 1'b1;
        clr_d            = clr_q + AW'(1);
        if (clr_last) begin
          state_d = pend_q ? StCalc1 : StIdle;
        end
      end
      StCalc1: state_d = StCalc2;
      StCalc2: state_d = StRead;
      StRead: begin
        lane_ctrl.rd_en = 1'b1;
        state_d         = StMul;
      end
      StMul: begin
        lane_ctrl.mul_en = 1'b1;
        state_d          = StOut;
      end
      StOut: begin
        if (out_free) begin
          lane_ctrl.wr_en = 1'b1;
          out_valid_d     = 1'b1;
          pend_d          = 1'b0;
          wp_d            = (wp_inc >= len_q) ? '0 : wp_inc[AW-1:0];
          state_d         = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StClear;
      clr_q         <= '0;
      wp_q          <= '0;
      was_playing_q <= 1'b0;
      pend_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      clr_q         <= clr_d;
      wp_q          <= wp_d;
      was_playing_q <= was_playing_d;
      pend_q        <= pend_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q[0] <= left_in_i;
      sample_q[1] <= right_in_i;
    end
    if (state_q == StCalc1) begin
      len_q <= len_d;
      dly_q <= dly_d;
      wpe_q <= wpe_d;
    end
    if (state_q == StCalc2) begin
      tap_q <= tap_d;
    end
    if (state_q == StRead) begin
      hit_q <= hit_d;
    end
    // The output register gathers the lane results into one request.
    if (lane_ctrl.wr_en) begin
      for (int i = 0; i < NumLanes; i++) begin
        out_q[i] <= result[i];
      end
    end
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    fdlr_lane #(
      .SampleWidth(SAMPLE_WIDTH),
      .MaxDepth   (MAX_DEPTH)
    ) u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (lane_ctrl),
      .rd_addr_i(rd_addr),
      .wr_addr_i(wr_addr),
      .sample_i (sample_q[g]),
      .gain_i   (gain_q),
      .result_o (result[g])
    );
  end

  assign left_out_o  = out_q[0];
  assign right_out_o = out_q[1];

endmodule

// ----- src/fdlr_ram.sv -----
module fdlr_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/fdlr_lane.sv -----
module fdlr_lane import fdlr_pkg::*; #(
  parameter int unsigned SampleWidth = SampleWidthDef,
  parameter int unsigned MaxDepth    = MaxDepthDef,
  localparam int unsigned AW         = $clog2(MaxDepth)
) (
  input  logic                          clk_i,
  input  lane_ctrl_t                    ctrl_i,
  input  logic [AW-1:0]                 rd_addr_i,
  input  logic [AW-1:0]                 wr_addr_i,
  input  logic signed [SampleWidth-1:0] sample_i,
  input  logic [GainW-1:0]              gain_i,
  output logic signed [SampleWidth-1:0] result_o
);

  localparam int unsigned ProdW = SampleWidth + GainW + 1;
  localparam int unsigned ScalW = ProdW - GainFrac;
  localparam int unsigned SumW  = SampleWidth + 3;

  logic [SampleWidth-1:0]        rd_data;
  logic [SampleWidth-1:0]        wr_data;
  logic signed [SampleWidth-1:0] tap;
  logic signed [ProdW-1:0]       prod_d, prod_q;
  logic signed [ProdW-1:0]       rounded;
  logic signed [ScalW-1:0]       scaled;
  logic signed [SumW-1:0]        sum;
  logic signed [SumW-1:0]        sat_max, sat_min;

  assign wr_data = ctrl_i.clr_en ? '0 : result_o;

  fdlr_ram #(
    .Width(SampleWidth),
    .Depth(MaxDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.clr_en | ctrl_i.wr_en),
    .waddr_i(wr_addr_i),
    .wdata_i(wr_data),
    .re_i   (ctrl_i.rd_en),
    .raddr_i(rd_addr_i),
    .rdata_o(rd_data)
  );

  // A tap at the write address uses the incoming dry sample, not the old entry.
  assign tap    = ctrl_i.hit ? sample_i : $signed(rd_data);
  assign prod_d = tap * $signed({1'b0, gain_i});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  // Round half up to the sample grid, then add the dry sample and saturate.
  assign rounded = prod_q + ProdW'(1 << (GainFrac - 1));
  assign scaled  = rounded[ProdW-1:GainFrac];
  assign sum     = SumW'(sample_i) + SumW'(scaled);
  assign sat_max = {{4{1'b0}}, {(SampleWidth-1){1'b1}}};
  assign sat_min = {{4{1'b1}}, {(SampleWidth-1){1'b0}}};

  always_comb begin
    if (sum > sat_max) begin
      result_o = sat_max[SampleWidth-1:0];
    end else if (sum < sat_min) begin
      result_o = sat_min[SampleWidth-1:0];
    end else begin
      result_o = sum[SampleWidth-1:0];
    end
  end

endmodule
